>>> sv/e8pd_pkg.sv
// Package for the EAN-8 bar pattern decoder: pipeline types, code tables
// and the group match and modulo-10 helpers.
// Depends on nothing; used by e8pd_decode and ean8_pattern_decoder_top.
package e8pd_pkg;

  localparam int unsigned HeadW   = 3;
  localparam int unsigned BodyW   = 64;
  localparam int unsigned GroupW  = 7;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NDigits = 8;
  localparam int unsigned NCodes  = 10;
  localparam int unsigned SumW    = 8;   // largest weighted sum is 135

  // Guard patterns
  localparam logic [2:0] StartGuard  = 3'b101;
  localparam logic [4:0] CentreGuard = 5'b01010;
  localparam logic [2:0] EndGuard    = 3'b101;

  // Low bit of each group in the body word
  localparam int unsigned LeftLsb0  = 57;
  localparam int unsigned RightLsb0 = 24;
  localparam int unsigned GroupStep = 7;
  localparam int unsigned CentreLsb = 31;

  typedef logic [DigitW-1:0] digit_t;
  typedef logic [GroupW-1:0] group_t;
  typedef digit_t [NDigits-1:0] digits_t;

  typedef logic [GroupW-1:0] code_tab_t [NCodes];

  // L codes (odd parity) and R codes, digit 0 first
  localparam code_tab_t LCodes = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
  };
  localparam code_tab_t RCodes = '{
    7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
  };

  typedef struct packed {
    digit_t digit;
    logic   miss;
  } match_t;

  // Stage one result: matched digits and error flags
  typedef struct packed {
    digits_t digits;
    logic    guard_err;
    logic    miss;
  } dec_t;

  // Match one group against a table; no match gives digit 0 and a miss
  function automatic match_t match_group(input group_t grp, input logic right);
    match_t res;
    logic   hit;
    res = '{digit: '0, miss: 1'b1};
    hit = 1'b0;
    for (int unsigned d = 0; d < NCodes; d++) begin
      if (!hit && grp == (right ? RCodes[d] : LCodes[d])) begin
        hit       = 1'b1;
        res.digit = DigitW'(d);
        res.miss  = 1'b0;
      end
    end
    return res;
  endfunction

  // Remainder modulo 10 of a sum below 160, by conditional subtraction
  function automatic digit_t mod10(input logic [SumW-1:0] val);
    logic [SumW-1:0] r;
    r = val;
    if (r >= SumW'(80)) r = r - SumW'(80);
    if (r >= SumW'(40)) r = r - SumW'(40);
    if (r >= SumW'(20)) r = r - SumW'(20);
    if (r >= SumW'(10)) r = r - SumW'(10);
    return r[DigitW-1:0];
  endfunction

endpackage

>>> sv/e8pd_decode.sv
// First pipeline stage of the EAN-8 decoder: guard checks and the eight
// table matches, registered. Depends on e8pd_pkg.
module e8pd_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        valid_i,
  input  logic [e8pd_pkg::HeadW-1:0]  head_i,
  input  logic [e8pd_pkg::BodyW-1:0]  body_i,
  output logic                        valid_o,
  output e8pd_pkg::dec_t              dec_o
);

  logic           valid_q;
  e8pd_pkg::dec_t dec_d, dec_q;

  // Check guards and match every group against its table
  always_comb begin
    e8pd_pkg::match_t m;
    dec_d.guard_err = (head_i != e8pd_pkg::StartGuard) ||
                      (body_i[e8pd_pkg::CentreLsb +: 5] != e8pd_pkg::CentreGuard) ||
                      (body_i[2:0] != e8pd_pkg::EndGuard);
    dec_d.miss   = 1'b0;
    dec_d.digits = '0;
    for (int unsigned g = 0; g < 4; g++) begin
      m = e8pd_pkg::match_group(
            body_i[e8pd_pkg::LeftLsb0 - g*e8pd_pkg::GroupStep +: e8pd_pkg::GroupW], 1'b0);
      dec_d.digits[g] = m.digit;
      dec_d.miss      = dec_d.miss | m.miss;
      m = e8pd_pkg::match_group(
            body_i[e8pd_pkg::RightLsb0 - g*e8pd_pkg::GroupStep +: e8pd_pkg::GroupW], 1'b1);
      dec_d.digits[g+4] = m.digit;
      dec_d.miss        = dec_d.miss | m.miss;
    end
  end

  // Advance the valid bit when the stage moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  // Hold the payload until a new request enters
  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

>>> sv/ean8_pattern_decoder_top.sv
// Top level of the EAN-8 bar pattern decoder: three-stage pipeline of
// match, weighted sum and check. Depends on e8pd_pkg and e8pd_decode.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, modules_*_i      | request in
//   out     | out_valid_o, out_stall_i, digit_*_o,     | result out
//           | guard_error_o, symbol_error_o, check_ok_o|
//
// One request per cycle while the output is not stalled; each result passes the
// match, sum and check registers before it can be taken at the output.
// Stages: table match, weighted sum, modulo-10 check into the output register.
// Reset clears the three stage valid bits only.
// A stall moves back stage by stage; empty stages still fill, so requests are
// taken while a finished result waits at the output.
module ean8_pattern_decoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [e8pd_pkg::HeadW-1:0]  modules_head_i,
  input  logic [e8pd_pkg::BodyW-1:0]  modules_body_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [e8pd_pkg::DigitW-1:0] digit_zero_o,
  output logic [e8pd_pkg::DigitW-1:0] digit_one_o,
  output logic [e8pd_pkg::DigitW-1:0] digit_two_o,
  output logic [e8pd_pkg::DigitW-1:0] digit_three_o,
  output logic [e8pd_pkg::DigitW-1:0] digit_four_o,
  output logic [e8pd_pkg::DigitW-1:0] digit_five_o,
  output logic [e8pd_pkg::DigitW-1:0] digit_six_o,
  output logic [e8pd_pkg::DigitW-1:0] digit_seven_o,
  output logic                        guard_error_o,
  output logic                        symbol_error_o,
  output logic                        check_ok_o
);

  logic                           s1_valid;
  e8pd_pkg::dec_t                 s1_dec;
  logic                           s2_valid_q, s3_valid_q;
  logic                           mv1, mv2, mv3;
  e8pd_pkg::dec_t                 s2_dec_q;
  logic [e8pd_pkg::SumW-1:0]      sum_d, s2_sum_q;
  e8pd_pkg::dec_t                 s3_dec_q;
  logic                           chk_ok_d, s3_chk_q;
  e8pd_pkg::digit_t               rem;
  e8pd_pkg::digit_t               chk_digit;

  // Stage moves when empty or when the stage after it moves
  assign mv3        = !s3_valid_q || !out_stall_i;
  assign mv2        = !s2_valid_q || mv3;
  assign mv1        = !s1_valid || mv2;
  assign in_stall_o = !mv1;

  // Stage one: guards and table matches
  e8pd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (mv1),
    .valid_i (in_valid_i),
    .head_i  (modules_head_i),
    .body_i  (modules_body_i),
    .valid_o (s1_valid),
    .dec_o   (s1_dec)
  );

  // Weighted sum: odd positions count three times
  always_comb begin
    logic [e8pd_pkg::SumW-1:0] odd_sum, even_sum;
    odd_sum  = e8pd_pkg::SumW'(s1_dec.digits[0]) + e8pd_pkg::SumW'(s1_dec.digits[2]) +
               e8pd_pkg::SumW'(s1_dec.digits[4]) + e8pd_pkg::SumW'(s1_dec.digits[6]);
    even_sum = e8pd_pkg::SumW'(s1_dec.digits[1]) + e8pd_pkg::SumW'(s1_dec.digits[3]) +
               e8pd_pkg::SumW'(s1_dec.digits[5]);
    sum_d    = (odd_sum << 1) + odd_sum + even_sum;
  end

  // Check digit from the remainder, compare with the eighth digit
  always_comb begin
    rem       = e8pd_pkg::mod10(s2_sum_q);
    chk_digit = (rem == '0) ? '0 : e8pd_pkg::DigitW'(10) - rem;
    chk_ok_d  = (s2_dec_q.digits[7] == chk_digit);
  end

  // Advance the valid bits of stages two and three
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (mv2) begin
        s2_valid_q <= s1_valid;
      end
      if (mv3) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Load stage payloads only when a request moves in
  always_ff @(posedge clk_i) begin
    if (mv2 && s1_valid) begin
      s2_dec_q <= s1_dec;
      s2_sum_q <= sum_d;
    end
    if (mv3 && s2_valid_q) begin
      s3_dec_q <= s2_dec_q;
      s3_chk_q <= chk_ok_d;
    end
  end

  // Drive the result ports from the output register
  assign out_valid_o    = s3_valid_q;
  assign digit_zero_o   = s3_dec_q.digits[0];
  assign digit_one_o    = s3_dec_q.digits[1];
  assign digit_two_o    = s3_dec_q.digits[2];
  assign digit_three_o  = s3_dec_q.digits[3];
  assign digit_four_o   = s3_dec_q.digits[4];
  assign digit_five_o   = s3_dec_q.digits[5];
  assign digit_six_o    = s3_dec_q.digits[6];
  assign digit_seven_o  = s3_dec_q.digits[7];
  assign guard_error_o  = s3_dec_q.guard_err;
  assign symbol_error_o = s3_dec_q.miss;
  assign check_ok_o     = s3_chk_q;

`ifndef SYNTH
  // Back-pressure reaches the input only with every stage full and the output held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && s2_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled while pipeline has room");

  // A blocked sum stage keeps its request and its sum
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !mv2) |=> (s2_valid_q && $stable(s2_sum_q)))
    else $error("sum stage lost or changed a held request");

  // Weighted sum of seven decimal digits never exceeds 135
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_sum_q <= e8pd_pkg::SumW'(135)))
    else $error("weighted sum out of range");

  // Delivered digits zero, three, four and seven are decimal
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_zero_o <= 4'd9 && digit_three_o <= 4'd9 &&
                     digit_four_o <= 4'd9 && digit_seven_o <= 4'd9))
    else $error("non-decimal digit delivered");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for ean8_pattern_decoder_top: builds EAN-8 bar
// patterns, predicts each decoded result and compares it on the output channel.
// Depends on the RTL only (e8pd_pkg for port widths).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;  // cycles with no handshake
  localparam int unsigned LongHold   = 80;    // receiver hold-off under pressure
  localparam int unsigned TailCycles = 8;

  // Standard EAN-8 codes, digit 0 first
  localparam logic [6:0] LeftCodes [10] = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
  };
  localparam logic [6:0] RightCodes [10] = '{
    7'h72, 7'h66, 7'h6C, 7'h42, 7'h5C, 7'h4E, 7'h50, 7'h44, 7'h48, 7'h74
  };

  typedef logic [7:0][3:0] digit_row_t;

  typedef struct packed {
    digit_row_t digits;
    logic       guard_err;
    logic       sym_err;
    logic       check_ok;
  } decode_result_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_stall_o;
  logic [e8pd_pkg::HeadW-1:0]        modules_head_i = '0;
  logic [e8pd_pkg::BodyW-1:0]        modules_body_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i    = 1'b0;
  logic [e8pd_pkg::DigitW-1:0]       digit_zero_o, digit_one_o, digit_two_o;
  logic [e8pd_pkg::DigitW-1:0]       digit_three_o, digit_four_o, digit_five_o;
  logic [e8pd_pkg::DigitW-1:0]       digit_six_o, digit_seven_o;
  logic                              guard_error_o, symbol_error_o, check_ok_o;

  decode_result_t expected_results[$];
  int unsigned    mismatches    = 0;
  int unsigned    patterns_sent = 0;
  int unsigned    guard_faults  = 0;
  int unsigned    symbol_faults = 0;
  int unsigned    checks_passed = 0;
  int unsigned    quiet_cycles  = 0;
  bit             idle_on       = 1'b1;
  bit             hold_request  = 1'b0;

  ean8_pattern_decoder_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .modules_head_i (modules_head_i),
    .modules_body_i (modules_body_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .digit_zero_o   (digit_zero_o),
    .digit_one_o    (digit_one_o),
    .digit_two_o    (digit_two_o),
    .digit_three_o  (digit_three_o),
    .digit_four_o   (digit_four_o),
    .digit_five_o   (digit_five_o),
    .digit_six_o    (digit_six_o),
    .digit_seven_o  (digit_seven_o),
    .guard_error_o  (guard_error_o),
    .symbol_error_o (symbol_error_o),
    .check_ok_o     (check_ok_o)
  );

  always #5 clk_i = ~clk_i;

  // Weighted modulo-10 check digit over the first seven digits
  function automatic logic [3:0] check_digit(input digit_row_t d);
    int unsigned total;
    total = 3 * (d[0] + d[2] + d[4] + d[6]) + d[1] + d[3] + d[5];
    return 4'((10 - total % 10) % 10);
  endfunction

  // Look a group up in one half's codes; no match gives 0 and raises miss
  function automatic logic [3:0] lookup_group(input logic [6:0] grp, input bit right_half,
                                              output logic miss);
    logic [3:0] digit;
    digit = '0;
    miss  = 1'b1;
    for (int d = 0; d < 10; d++) begin
      if (grp == (right_half ? RightCodes[d] : LeftCodes[d])) begin
        digit = 4'(d);
        miss  = 1'b0;
      end
    end
    return digit;
  endfunction

  // Predict the decoded result of one bar pattern
  function automatic decode_result_t decode_pattern(input logic [2:0] head,
                                                    input logic [63:0] body);
    decode_result_t res;
    logic           miss;
    res.sym_err   = 1'b0;
    res.guard_err = (head != 3'b101) || (body[35:31] != 5'b01010) || (body[2:0] != 3'b101);
    for (int g = 0; g < 4; g++) begin
      res.digits[g]     = lookup_group(body[63-7*g -: 7], 1'b0, miss);
      res.sym_err       = res.sym_err | miss;
      res.digits[g + 4] = lookup_group(body[30-7*g -: 7], 1'b1, miss);
      res.sym_err       = res.sym_err | miss;
    end
    res.check_ok = (res.digits[7] == check_digit(res.digits));
    return res;
  endfunction

  // Lay out a well-formed body with guards for the given digits
  function automatic logic [63:0] encode_body(input digit_row_t d);
    logic [63:0] body;
    body        = '0;
    body[2:0]   = 3'b101;
    body[35:31] = 5'b01010;
    for (int g = 0; g < 4; g++) begin
      body[63-7*g -: 7] = LeftCodes[d[g]];
      body[30-7*g -: 7] = RightCodes[d[g + 4]];
    end
    return body;
  endfunction

  function automatic digit_row_t random_digits(input bit with_check);
    digit_row_t d;
    for (int i = 0; i < 8; i++) d[i] = 4'($urandom_range(0, 9));
    if (with_check) d[7] = check_digit(d);
    return d;
  endfunction

  // Offer one request after a random gap and hold it until it is taken
  task automatic send_pattern(input logic [2:0] head, input logic [63:0] body);
    int unsigned    gap;
    decode_result_t exp;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    modules_head_i <= head;
    modules_body_i <= body;
    do @(posedge clk_i); while (in_stall_o);
    exp = decode_pattern(head, body);
    expected_results.push_back(exp);
    patterns_sent++;
    guard_faults  += exp.guard_err;
    symbol_faults += exp.sym_err;
    checks_passed += exp.check_ok;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_all_done();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Every L and R code in every position
  task automatic test_all_codes();
    digit_row_t d;
    for (int base = 0; base < 10; base++) begin
      for (int i = 0; i < 8; i++) d[i] = 4'((base + i) % 10);
      send_pattern(3'b101, encode_body(d));
    end
  endtask

  // Correct and wrong check digits, including a stand-in zero
  task automatic test_check_digit();
    digit_row_t  d;
    logic [63:0] body;
    send_pattern(3'b101, encode_body('0));
    d = random_digits(1'b1);
    send_pattern(3'b101, encode_body(d));
    d[7] = 4'((d[7] + 1) % 10);
    send_pattern(3'b101, encode_body(d));
    // unmatched second group counts as 0 in the sum
    d    = random_digits(1'b0);
    d[1] = 4'd0;
    d[7] = check_digit(d);
    body = encode_body(d);
    body[56:50] = 7'h00;
    send_pattern(3'b101, body);
  endtask

  // Each guard broken on its own, then all together
  task automatic test_guards();
    logic [63:0] body;
    body = encode_body(random_digits(1'b1));
    send_pattern(3'b000, body);
    send_pattern(3'b111, body);
    send_pattern(3'b101, body ^ 64'h2_0000_0000);
    send_pattern(3'b101, body ^ 64'h1);
    send_pattern(3'b010, body ^ 64'h7_8000_0007);
  endtask

  // Groups that match no code, in either half
  task automatic test_unmatched();
    logic [63:0] body;
    body = encode_body(random_digits(1'b1));
    body[63:57] = 7'h00;
    body[9:3]   = 7'h7F;
    send_pattern(3'b101, body);
    body = encode_body(random_digits(1'b1));
    body[30:24] = LeftCodes[3];
    send_pattern(3'b101, body);
    body = encode_body(random_digits(1'b1));
    body[42:36] = RightCodes[6];
    send_pattern(3'b101, body);
    body = encode_body(random_digits(1'b1));
    for (int g = 0; g < 4; g++) begin
      body[63-7*g -: 7] = RightCodes[g];
      body[30-7*g -: 7] = LeftCodes[g + 4];
    end
    send_pattern(3'b101, body);
  endtask

  // All-zero and all-one fields
  task automatic test_extremes();
    send_pattern(3'b000, '0);
    send_pattern(3'b111, '1);
    send_pattern(3'b101, '1);
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) send_pattern(3'b101, encode_body(random_digits(1'b1)));
    idle_on = 1'b1;
  endtask

  // Pause the sender until the pipeline has drained
  task automatic test_drain_pause();
    for (int i = 0; i < 8; i++) send_pattern(3'b101, encode_body(random_digits(1'b1)));
    wait_all_done();
    for (int i = 0; i < 8; i++) send_pattern(3'b101, encode_body(random_digits(1'b0)));
  endtask

  // Mostly well-formed patterns, mixed with damaged ones and plain noise
  task automatic test_random_patterns(input int unsigned count);
    int unsigned kind;
    int unsigned pos;
    logic [66:0] all;
    logic [63:0] body;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      body = encode_body(random_digits(kind < 55));
      all  = {3'b101, body};
      if (kind >= 70 && kind < 85) begin
        all[$urandom_range(0, 66)] ^= 1'b1;
        if ($urandom_range(0, 1)) all[$urandom_range(0, 66)] ^= 1'b1;
      end else if (kind >= 85 && kind < 92) begin
        pos = $urandom_range(0, 7);
        if (pos < 4) all[63-7*pos -: 7] = 7'($urandom);
        else all[30-7*(pos-4) -: 7] = 7'($urandom);
      end else if (kind >= 92) begin
        all = {3'($urandom), $urandom, $urandom};
      end
      send_pattern(all[66:64], all[63:0]);
    end
    idle_on = 1'b1;
  endtask

  // Stall the output for a drawn number of cycles before each result
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold         = LongHold;
        hold_request = 1'b0;
      end else begin
        hold = idle_on ? $urandom_range(0, 5) : 0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Compare each result taken with the oldest prediction
  always @(posedge clk_i) begin
    decode_result_t got, exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.digits = {digit_seven_o, digit_six_o, digit_five_o, digit_four_o,
                    digit_three_o, digit_two_o, digit_one_o, digit_zero_o};
      got.guard_err = guard_error_o;
      got.sym_err   = symbol_error_o;
      got.check_ok  = check_ok_o;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        mismatches++;
      end else begin
        exp = expected_results.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got.digits[i] !== exp.digits[i]) begin
            $display("%0t: digit %0d expected %0d, got %0d", $time, i,
                     exp.digits[i], got.digits[i]);
            mismatches++;
          end
        end
        if (got.guard_err !== exp.guard_err) begin
          $display("%0t: guard_error expected %b, got %b", $time, exp.guard_err,
                   got.guard_err);
          mismatches++;
        end
        if (got.sym_err !== exp.sym_err) begin
          $display("%0t: symbol_error expected %b, got %b", $time, exp.sym_err,
                   got.sym_err);
          mismatches++;
        end
        if (got.check_ok !== exp.check_ok) begin
          $display("%0t: check_ok expected %b, got %b", $time, exp.check_ok,
                   got.check_ok);
          mismatches++;
        end
      end
    end
  end

  // Abort when no request moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, expected_results.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_all_codes();
    test_check_digit();
    test_guards();
    test_unmatched();
    test_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_patterns(1500);
    wait_all_done();
    repeat (TailCycles) @(posedge clk_i);
    $display("Decoded %0d patterns under random gaps and output stalls:", patterns_sent);
    $display("  %0d with guard faults, %0d with unmatched groups, %0d passing the check",
             guard_faults, symbol_faults, checks_passed);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/e8pd_pkg.sv
sv/e8pd_decode.sv
sv/ean8_pattern_decoder_top.sv
tb/testbench.sv
